FILE: hw/rtl/breathing_led_color_cycler_core_defines.svh
// ----------------------------------------------------------------------------
// Breathing LED colour cycler assertion macros
// Shared assertion shorthands for the colour cycler RTL.
// ----------------------------------------------------------------------------
`ifndef BREATHING_LED_COLOR_CYCLER_CORE_DEFINES_SVH
`define BREATHING_LED_COLOR_CYCLER_CORE_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define BLCC_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("blcc assertion failed");

// check a condition in the cycle after its trigger
`define BLCC_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("blcc assertion failed");

`endif

FILE: hw/rtl/blcc_pkg.sv
// ----------------------------------------------------------------------------
// Breathing LED colour cycler package
// Commands, modes, register indexes, constants and the colour table.
// ----------------------------------------------------------------------------
`default_nettype none

package blcc_pkg;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_STEADY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_BREATHING = 2'd1,
    MODE_STEADY    = 2'd2
  } mode_t;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_INTERVAL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_PERIOD  = 1'd1;

  localparam logic [31:0] COLOR_INTERVAL_RESET = 32'd5000;
  localparam logic [15:0] UPDATE_PERIOD_RESET  = 16'd10;

  localparam logic [3:0] TABLE_COLORS = 4'd7;
  localparam logic [7:0] BRIGHT_STEP  = 8'd5;
  localparam logic [7:0] BRIGHT_MAX   = 8'd255;

  typedef struct packed {
    logic       scaled;
    logic [2:0] color_index;
    logic [7:0] brightness;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } stage_t;

  function automatic logic [23:0] palette(input logic [2:0] idx);
    logic [23:0] rgb;
    case (idx)
      3'd0:    rgb = {8'hFF, 8'h00, 8'hE1};
      3'd1:    rgb = {8'hFF, 8'h00, 8'h00};
      3'd2:    rgb = {8'h00, 8'hFF, 8'h00};
      3'd3:    rgb = {8'h00, 8'h00, 8'hFF};
      3'd4:    rgb = {8'hFF, 8'hFF, 8'h00};
      3'd5:    rgb = {8'h00, 8'hFF, 8'hFF};
      3'd6:    rgb = {8'hFF, 8'hFF, 8'hFF};
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/blcc_if.sv
// ----------------------------------------------------------------------------
// Breathing LED colour cycler channels
// Valid/ready channels for commands, colour results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface blcc_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_ms;
  logic [7:0]  steady_red;
  logic [7:0]  steady_green;
  logic [7:0]  steady_blue;

  modport source (output valid, command, now_ms, steady_red, steady_green, steady_blue,
                  input ready);
  modport sink   (input valid, command, now_ms, steady_red, steady_green, steady_blue,
                  output ready);
endinterface

interface blcc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface blcc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [blcc_pkg::CFG_INDEX_W-1:0]    index;
  logic [blcc_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/blcc_scaler.sv
// ----------------------------------------------------------------------------
// Breathing LED colour cycler scaler
// Scales the table colour by brightness/255, or passes a direct colour.
// ----------------------------------------------------------------------------
`default_nettype none

module blcc_scaler (
  input  blcc_pkg::stage_t stage,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  logic [23:0] table_rgb;

  function automatic logic [7:0] scale(input logic [7:0] v, input logic [7:0] b);
    logic [15:0] prod;
    logic [15:0] sum;
    prod = 16'(v) * 16'(b);
    sum  = prod + {8'd0, prod[15:8]} + 16'd1;
    return sum[15:8];
  endfunction

  always_comb begin
    table_rgb = blcc_pkg::palette(stage.color_index);
    if (stage.scaled) begin
      red   = scale(table_rgb[23:16], stage.brightness);
      green = scale(table_rgb[15:8],  stage.brightness);
      blue  = scale(table_rgb[7:0],   stage.brightness);
    end else begin
      red   = stage.red;
      green = stage.green;
      blue  = stage.blue;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/breathing_led_color_cycler_core.sv
// ----------------------------------------------------------------------------
// Breathing LED colour cycler core
// Command-driven breathing, steady and off colour control for an LED string.
// ----------------------------------------------------------------------------
// Usage:
//   item   : command transactions (poll, start, stop, steady) with now_ms.
//   result : one colour transaction for stop, steady, and for each poll in
//            breathing mode that takes a brightness step; none otherwise.
//   cfg    : register writes, index 0 colour interval, 1 update period;
//            always ready, write only while no command is in flight.
//   State is updated in the cycle a command is taken. A result sits in an
//   internal stage (table colour scaling) and then in the output register.
//   Throughput is one command per cycle while item.ready is high, set by
//   the single state update.
//   When the receiver stalls, one result waits in the output register and
//   one in the internal stage; item.ready drops only when both are full.
//   Every command then waits, including those that give no result.
//   Reset clears the mode, brightness, direction, times and colour index and
//   restores the registers to 5000 ms and 10 ms.
// ----------------------------------------------------------------------------
`default_nettype none
`include "breathing_led_color_cycler_core_defines.svh"

module breathing_led_color_cycler_core (
  input  wire logic      clk,
  input  wire logic      rst,
  blcc_item_if.sink      item,
  blcc_result_if.source  result,
  blcc_cfg_if.sink       cfg
);

  logic [31:0]         color_interval_ms;
  logic [15:0]         update_period_ms;

  blcc_pkg::mode_t     effect_mode, effect_mode_next;
  logic [7:0]          brightness, brightness_next;
  logic                dimming, dimming_next;
  logic [31:0]         last_step_time, last_step_time_next;
  logic [2:0]          color_index, color_index_next;
  logic [31:0]         last_color_change_time, last_color_change_time_next;

  logic                s1_valid;
  blcc_pkg::stage_t    s1_stage, s1_stage_next;
  logic                s1_adv;
  logic                accept;
  logic                emit;

  logic [31:0]         color_elapsed;
  logic [31:0]         step_elapsed;
  logic [3:0]          idx_inc;
  logic [8:0]          bright_sum;
  logic [7:0]          scaled_red, scaled_green, scaled_blue;

  assign cfg.ready  = 1'b1;
  assign s1_adv     = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_interval_ms <= blcc_pkg::COLOR_INTERVAL_RESET;
      update_period_ms  <= blcc_pkg::UPDATE_PERIOD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        blcc_pkg::CFG_COLOR_INTERVAL: color_interval_ms <= cfg.data;
        blcc_pkg::CFG_UPDATE_PERIOD:  update_period_ms  <= cfg.data[15:0];
      endcase
    end
  end

  always_comb begin
    effect_mode_next            = effect_mode;
    brightness_next             = brightness;
    dimming_next                = dimming;
    last_step_time_next         = last_step_time;
    color_index_next            = color_index;
    last_color_change_time_next = last_color_change_time;
    emit                        = 1'b0;
    s1_stage_next               = '0;

    color_elapsed = item.now_ms - last_color_change_time;
    step_elapsed  = item.now_ms - last_step_time;
    idx_inc       = {1'b0, color_index} + 4'd1;
    bright_sum    = {1'b0, brightness} + {1'b0, blcc_pkg::BRIGHT_STEP};

    unique case (blcc_pkg::cmd_t'(item.command))
      blcc_pkg::CMD_START: begin
        effect_mode_next    = blcc_pkg::MODE_BREATHING;
        brightness_next     = 8'd0;
        dimming_next        = 1'b0;
        last_step_time_next = item.now_ms;
      end
      blcc_pkg::CMD_STOP: begin
        effect_mode_next = blcc_pkg::MODE_OFF;
        emit             = 1'b1;
      end
      blcc_pkg::CMD_STEADY: begin
        effect_mode_next    = blcc_pkg::MODE_STEADY;
        emit                = 1'b1;
        s1_stage_next.red   = item.steady_red;
        s1_stage_next.green = item.steady_green;
        s1_stage_next.blue  = item.steady_blue;
      end
      blcc_pkg::CMD_POLL: begin
        if (color_elapsed > color_interval_ms) begin
          color_index_next            = (idx_inc >= blcc_pkg::TABLE_COLORS) ?
                                        3'd0 : idx_inc[2:0];
          last_color_change_time_next = item.now_ms;
        end
        if (step_elapsed >= {16'd0, update_period_ms}) begin
          last_step_time_next = item.now_ms;
          if (effect_mode == blcc_pkg::MODE_BREATHING) begin
            if (dimming) begin
              brightness_next = (brightness > blcc_pkg::BRIGHT_STEP) ?
                                brightness - blcc_pkg::BRIGHT_STEP : 8'd0;
              dimming_next    = (brightness_next != 8'd0);
            end else begin
              brightness_next = (bright_sum > {1'b0, blcc_pkg::BRIGHT_MAX}) ?
                                blcc_pkg::BRIGHT_MAX : bright_sum[7:0];
              dimming_next    = (brightness_next == blcc_pkg::BRIGHT_MAX);
            end
            emit                      = 1'b1;
            s1_stage_next.scaled      = 1'b1;
            s1_stage_next.color_index = color_index_next;
            s1_stage_next.brightness  = brightness_next;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode            <= blcc_pkg::MODE_OFF;
      brightness             <= 8'd0;
      dimming                <= 1'b0;
      last_step_time         <= 32'd0;
      color_index            <= 3'd0;
      last_color_change_time <= 32'd0;
    end else if (accept) begin
      effect_mode            <= effect_mode_next;
      brightness             <= brightness_next;
      dimming                <= dimming_next;
      last_step_time         <= last_step_time_next;
      color_index            <= color_index_next;
      last_color_change_time <= last_color_change_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && emit) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_stage <= s1_stage_next;
    end
  end

  blcc_scaler u_scaler (
    .stage (s1_stage),
    .red   (scaled_red),
    .green (scaled_green),
    .blue  (scaled_blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.red   <= scaled_red;
      result.green <= scaled_green;
      result.blue  <= scaled_blue;
    end
  end

  `BLCC_ASSERT_SAME(a_dim_nonzero, dimming, brightness != 8'd0)
  `BLCC_ASSERT_SAME(a_rise_below_max, !dimming, brightness != blcc_pkg::BRIGHT_MAX)
  `BLCC_ASSERT_SAME(a_index_range, 1'b1, {1'b0, color_index} < blcc_pkg::TABLE_COLORS)
  `BLCC_ASSERT_SAME(a_full_blocks, s1_valid && result.valid && !result.ready, !item.ready)
  `BLCC_ASSERT_NEXT(a_stop_emits, accept && item.command == blcc_pkg::CMD_STOP, s1_valid)

endmodule

`default_nettype wire
